// File: hdl/lpp_pkg.sv
package lpp_pkg;

  localparam int READING_BITS = 16;

  localparam int THR_BITS   = 18;
  localparam int REF_BITS   = 8;
  localparam int DIVR_BITS  = 8;
  localparam int LIMIT_BITS = 12;
  localparam int CFG_BITS   = 18;
  localparam int CFG_IDX_BITS = 3;

  localparam int ERR_BITS    = 9;
  localparam int EFFORT_BITS = 13;
  localparam int POS_BITS    = 8;
  localparam int OPND_BITS   = 12;
  localparam int QUOT_BITS   = 11;
  localparam int CNT_BITS    = 4;
  localparam int PC_BITS     = 4;

  localparam logic [CNT_BITS-1:0] POS_ITERS_M1 = CNT_BITS'(POS_BITS - 1);
  localparam logic [CNT_BITS-1:0] PID_ITERS_M1 = CNT_BITS'(QUOT_BITS - 1);

  localparam logic [POS_BITS-1:0]   POS_MAX = POS_BITS'(200);
  localparam logic [THR_BITS-1:0]   THR_RESET = '0;
  localparam logic [REF_BITS-1:0]   REF_RESET = REF_BITS'(100);
  localparam logic [DIVR_BITS-1:0]  DIVR_RESET = DIVR_BITS'(1);
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(2200);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_THRESHOLD = 3'd0,
    CFG_REFERENCE = 3'd1,
    CFG_PROP_DIV  = 3'd2,
    CFG_INTEG_DIV = 3'd3,
    CFG_DERIV_DIV = 3'd4,
    CFG_LIMIT     = 3'd5
  } cfg_reg_e;

  typedef enum logic [2:0] {
    UOP_WAIT,
    UOP_LOAD,
    UOP_DIV,
    UOP_ERR,
    UOP_ACC,
    UOP_EMIT
  } uop_e;

  typedef enum logic [1:0] {
    SRC_POS,
    SRC_PROP,
    SRC_INTEG,
    SRC_DERIV
  } src_e;

  typedef enum logic [1:0] {
    HOLD_NONE,
    HOLD_REQ,
    HOLD_CNT,
    HOLD_OUT
  } hold_e;

  typedef struct packed {
    uop_e               op;
    src_e               src;
    hold_e              hold;
    logic [PC_BITS-1:0] nxt;
  } ucode_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

  function automatic ucode_t ucode(logic [PC_BITS-1:0] addr);
    ucode_t w;
    case (addr)
      4'd0:    w = '{UOP_WAIT, SRC_POS,   HOLD_REQ,  4'd1};
      4'd1:    w = '{UOP_LOAD, SRC_POS,   HOLD_NONE, 4'd2};
      4'd2:    w = '{UOP_DIV,  SRC_POS,   HOLD_CNT,  4'd3};
      4'd3:    w = '{UOP_ERR,  SRC_POS,   HOLD_NONE, 4'd4};
      4'd4:    w = '{UOP_LOAD, SRC_PROP,  HOLD_NONE, 4'd5};
      4'd5:    w = '{UOP_DIV,  SRC_PROP,  HOLD_CNT,  4'd6};
      4'd6:    w = '{UOP_ACC,  SRC_PROP,  HOLD_NONE, 4'd7};
      4'd7:    w = '{UOP_LOAD, SRC_INTEG, HOLD_NONE, 4'd8};
      4'd8:    w = '{UOP_DIV,  SRC_INTEG, HOLD_CNT,  4'd9};
      4'd9:    w = '{UOP_ACC,  SRC_INTEG, HOLD_NONE, 4'd10};
      4'd10:   w = '{UOP_LOAD, SRC_DERIV, HOLD_NONE, 4'd11};
      4'd11:   w = '{UOP_DIV,  SRC_DERIV, HOLD_CNT,  4'd12};
      4'd12:   w = '{UOP_ACC,  SRC_DERIV, HOLD_NONE, 4'd13};
      4'd13:   w = '{UOP_EMIT, SRC_POS,   HOLD_OUT,  4'd0};
      default: w = '{UOP_WAIT, SRC_POS,   HOLD_NONE, 4'd0};
    endcase
    return w;
  endfunction

endpackage

// File: hdl/lpp_divider.sv
module lpp_divider #(
  parameter int RW = lpp_pkg::READING_BITS + 3,
  parameter int QW = lpp_pkg::QUOT_BITS
) (
  input  logic                clk_i,
  input  lpp_pkg::div_ctrl_t  ctrl_i,
  input  logic [RW-1:0]       rem_i,
  input  logic [QW-1:0]       dq_i,
  input  logic [RW-2:0]       den_i,
  output logic [QW-1:0]       quot_o
);

  logic [RW-1:0] rem_q, rem_d;
  logic [QW-1:0] dq_q, dq_d;
  logic [RW-2:0] den_q, den_d;
  logic [RW-1:0] trial;
  logic [RW-1:0] den_x;

  always_comb begin
    trial = {rem_q[RW-2:0], dq_q[QW-1]};
    den_x = {1'b0, den_q};
    rem_d = rem_q;
    dq_d  = dq_q;
    den_d = den_q;
    if (ctrl_i.load) begin
      rem_d = rem_i;
      dq_d  = dq_i;
      den_d = den_i;
    end else if (ctrl_i.step) begin
      if (trial >= den_x) begin
        rem_d = trial - den_x;
        dq_d  = {dq_q[QW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        dq_d  = {dq_q[QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dq_q  <= dq_d;
    den_q <= den_d;
  end

  assign quot_o = dq_q;

endmodule

// File: hdl/line_position_pid_unit.sv
// Line-follower steering controller. Each request carries the three sensor
// periods; the block answers with one control effort and the position error.
// The result is offered once the program reaches its emit step and the result
// port is free; a new request is accepted only after that, at the wait step. A
// small microcode program steps one shared shift-subtract divider, one
// quotient bit per cycle, through the 8-bit position division and the three
// 11-bit term divisions (proportional, first and second difference).
// The next request is taken as soon as the program returns to its wait step,
// while the previous result may still sit in the output register. Register
// writes go through the plain write port and are meant for idle periods only.
module line_position_pid_unit #(
  parameter int READING_BITS = lpp_pkg::READING_BITS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [lpp_pkg::CFG_IDX_BITS-1:0]      cfg_idx_i,
  input  logic [lpp_pkg::CFG_BITS-1:0]          cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [READING_BITS-1:0]               reading_left_i,
  input  logic [READING_BITS-1:0]               reading_center_i,
  input  logic [READING_BITS-1:0]               reading_right_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [lpp_pkg::EFFORT_BITS-1:0] control_effort_o,
  output logic signed [lpp_pkg::ERR_BITS-1:0]    position_error_o
);

  localparam int SUM_W = READING_BITS + 2;
  localparam int NUM_W = READING_BITS + 9;
  localparam int REM_W = READING_BITS + 3;
  localparam int CMP_W = (SUM_W > lpp_pkg::THR_BITS) ? SUM_W : lpp_pkg::THR_BITS;
  localparam int QW    = lpp_pkg::QUOT_BITS;
  localparam int PW    = lpp_pkg::POS_BITS;
  localparam int EW    = lpp_pkg::EFFORT_BITS;
  localparam int OW    = lpp_pkg::OPND_BITS;

  logic [lpp_pkg::THR_BITS-1:0]   thr_q;
  logic [lpp_pkg::REF_BITS-1:0]   ref_q;
  logic [lpp_pkg::DIVR_BITS-1:0]  kp_q, ki_q, kd_q;
  logic [lpp_pkg::LIMIT_BITS-1:0] limit_q;

  logic [lpp_pkg::PC_BITS-1:0]  pc_q, pc_d;
  logic [lpp_pkg::CNT_BITS-1:0] cnt_q, cnt_d;
  lpp_pkg::ucode_t              uw;
  logic                         in_acc, out_free, hold;

  logic [SUM_W-1:0] sum_q, sum_d;
  logic [NUM_W-1:0] num_q, num_d;
  logic [NUM_W-1:0] cx, rx;

  logic signed [lpp_pkg::ERR_BITS-1:0] e0_q, e0_d, e1_q, e1_d, e2_q, e2_d;
  logic signed [lpp_pkg::ERR_BITS-1:0] err_q, err_d;
  logic signed [EW-1:0] last_q, last_d, acc_q, acc_d;
  logic signed [EW-1:0] eff_q, eff_d, eff_new, lmag;
  logic                 out_valid_q, out_valid_d;
  logic                 neg_q, neg_d;

  lpp_pkg::div_ctrl_t       dctl;
  logic [REM_W-1:0]         rem_init;
  logic [QW-1:0]            dq_init, quot;
  logic [REM_W-2:0]         den;
  logic [lpp_pkg::DIVR_BITS-1:0] kdiv;

  logic signed [OW-1:0] e0x, e1x, e2x, opnd, omag;
  logic [PW-1:0]        pos;
  logic [EW-1:0]        qx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= lpp_pkg::THR_RESET;
      ref_q   <= lpp_pkg::REF_RESET;
      kp_q    <= lpp_pkg::DIVR_RESET;
      ki_q    <= lpp_pkg::DIVR_RESET;
      kd_q    <= lpp_pkg::DIVR_RESET;
      limit_q <= lpp_pkg::LIMIT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lpp_pkg::CFG_THRESHOLD: thr_q   <= cfg_data_i[lpp_pkg::THR_BITS-1:0];
        lpp_pkg::CFG_REFERENCE: ref_q   <= cfg_data_i[lpp_pkg::REF_BITS-1:0];
        lpp_pkg::CFG_PROP_DIV:  kp_q    <= cfg_data_i[lpp_pkg::DIVR_BITS-1:0];
        lpp_pkg::CFG_INTEG_DIV: ki_q    <= cfg_data_i[lpp_pkg::DIVR_BITS-1:0];
        lpp_pkg::CFG_DERIV_DIV: kd_q    <= cfg_data_i[lpp_pkg::DIVR_BITS-1:0];
        lpp_pkg::CFG_LIMIT:     limit_q <= cfg_data_i[lpp_pkg::LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    uw         = lpp_pkg::ucode(pc_q);
    in_ready_o = (uw.op == lpp_pkg::UOP_WAIT);
    in_acc     = in_valid_i && in_ready_o;
    out_free   = !out_valid_q || out_ready_i;
    case (uw.hold)
      lpp_pkg::HOLD_REQ: hold = !in_acc;
      lpp_pkg::HOLD_CNT: hold = (cnt_q != '0);
      lpp_pkg::HOLD_OUT: hold = !out_free;
      default:           hold = 1'b0;
    endcase
    pc_d = hold ? pc_q : uw.nxt;
  end

  // operand selection
  always_comb begin
    e0x = OW'(e0_q);
    e1x = OW'(e1_q);
    e2x = OW'(e2_q);
    case (uw.src)
      lpp_pkg::SRC_PROP:  begin opnd = e0x;                              kdiv = kp_q; end
      lpp_pkg::SRC_INTEG: begin opnd = e0x - e1x;                        kdiv = ki_q; end
      lpp_pkg::SRC_DERIV: begin opnd = (e0x - (e1x <<< 1) + e2x) <<< 1;  kdiv = kd_q; end
      default:            begin opnd = '0;                               kdiv = kp_q; end
    endcase
    omag = opnd[OW-1] ? -opnd : opnd;
    if (uw.src == lpp_pkg::SRC_POS) begin
      rem_init = {2'b00, num_q[NUM_W-1:PW]};
      dq_init  = {num_q[PW-1:0], (QW-PW)'(0)};
      den      = sum_q;
    end else begin
      rem_init = '0;
      dq_init  = omag[QW-1:0];
      den      = (REM_W-1)'((kdiv == '0) ? lpp_pkg::DIVR_BITS'(1) : kdiv);
    end
    dctl.load = (uw.op == lpp_pkg::UOP_LOAD);
    dctl.step = (uw.op == lpp_pkg::UOP_DIV);
  end

  lpp_divider #(
    .RW(REM_W),
    .QW(QW)
  ) u_div (
    .clk_i (clk_i),
    .ctrl_i(dctl),
    .rem_i (rem_init),
    .dq_i  (dq_init),
    .den_i (den),
    .quot_o(quot)
  );

  // datapath
  always_comb begin
    cx = NUM_W'(reading_center_i);
    rx = NUM_W'(reading_right_i);
    sum_d = sum_q;
    num_d = num_q;
    cnt_d = cnt_q;
    neg_d = neg_q;
    e0_d  = e0_q;
    e1_d  = e1_q;
    e2_d  = e2_q;
    acc_d = acc_q;
    last_d = last_q;
    eff_d  = eff_q;
    err_d  = err_q;
    out_valid_d = out_valid_q && !out_ready_i;

    pos = (sum_q == '0) ? '0 : quot[PW-1:0];
    if (CMP_W'(sum_q) < CMP_W'(thr_q)) begin
      if (e0_q < 0) pos = '0;
      if (e0_q > 0) pos = lpp_pkg::POS_MAX;
    end

    qx = {(EW-QW)'(0), quot};

    lmag = last_q[EW-1] ? -last_q : last_q;
    if (lmag >= $signed({1'b0, limit_q})) begin
      if (last_q > 0)      eff_new = $signed({1'b0, limit_q});
      else if (last_q < 0) eff_new = -$signed({1'b0, limit_q});
      else                 eff_new = '0;
    end else begin
      eff_new = acc_q;
    end

    case (uw.op)
      lpp_pkg::UOP_WAIT: begin
        if (in_acc) begin
          sum_d = SUM_W'(reading_left_i) + SUM_W'(reading_center_i) +
                  SUM_W'(reading_right_i);
          num_d = (cx << 6) + (cx << 5) + (cx << 2) + (rx << 7) + (rx << 6) + (rx << 3);
        end
      end
      lpp_pkg::UOP_LOAD: begin
        cnt_d = (uw.src == lpp_pkg::SRC_POS) ? lpp_pkg::POS_ITERS_M1
                                             : lpp_pkg::PID_ITERS_M1;
        neg_d = opnd[OW-1];
      end
      lpp_pkg::UOP_DIV: begin
        if (cnt_q != '0) cnt_d = cnt_q - 1'b1;
      end
      lpp_pkg::UOP_ERR: begin
        e2_d  = e1_q;
        e1_d  = e0_q;
        e0_d  = $signed({1'b0, pos}) - $signed({1'b0, ref_q});
        acc_d = '0;
      end
      lpp_pkg::UOP_ACC: begin
        acc_d = neg_q ? acc_q - $signed(qx) : acc_q + $signed(qx);
      end
      lpp_pkg::UOP_EMIT: begin
        if (out_free) begin
          eff_d       = eff_new;
          err_d       = e0_q;
          last_d      = eff_new;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= '0;
      cnt_q       <= '0;
      e0_q        <= '0;
      e1_q        <= '0;
      e2_q        <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      cnt_q       <= cnt_d;
      e0_q        <= e0_d;
      e1_q        <= e1_d;
      e2_q        <= e2_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    num_q <= num_d;
    neg_q <= neg_d;
    acc_q <= acc_d;
    eff_q <= eff_d;
    err_q <= err_d;
  end

  assign out_valid_o      = out_valid_q;
  assign control_effort_o = eff_q;
  assign position_error_o = err_q;

endmodule
